// File: rtl/ordered_list_insert_search_unit_macros.svh
// Assertion macros for the ordered list insert/search unit.
// Used by the port checker; expects i_clk and i_rst_n in scope.
`ifndef ORDERED_LIST_INSERT_SEARCH_UNIT_MACROS_SVH
`define ORDERED_LIST_INSERT_SEARCH_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define OLIS_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("olis: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define OLIS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("olis: next-cycle check failed");

`endif

// File: rtl/olis_pkg.sv
// Shared types and codes for the ordered list insert/search unit.
// No dependencies; imported by the cells, the chain, the top level and the checker.
package olis_pkg;

    // Field widths fixed by the stream format
    localparam int CMD_W  = 2;
    localparam int POS_W  = 5;
    localparam int KIND_W = 2;

    // Input command codes
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DUMP   = 2'd2;

    // Result kind codes
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DUMP   = 2'd2;

    // Operation broadcast to every cell of the chain
    typedef logic [1:0] t_cell_op;
    localparam t_cell_op OP_HOLD   = 2'd0;
    localparam t_cell_op OP_INSERT = 2'd1;
    localparam t_cell_op OP_SEARCH = 2'd2;
    localparam t_cell_op OP_ROTATE = 2'd3;

    typedef struct packed {
        t_cell_op op;
        logic     full;
    } t_cell_cmd;

endpackage

// File: rtl/olis_cell.sv
// One list slot: holds an entry, shifts it on insert, rotates it on dump,
// and compares it against the search key. Depends on olis_pkg.
module olis_cell #(
    parameter int IDX = 0,
    parameter int VW  = 8,
    parameter int CW  = 5
) (
    input  logic                  i_clk,
    input  olis_pkg::t_cell_cmd   i_cmd,
    input  logic [CW-1:0]         i_slot,
    input  logic [CW-1:0]         i_len,
    input  logic [VW-1:0]         i_prev,
    input  logic [VW-1:0]         i_next,
    input  logic [VW-1:0]         i_head,
    input  logic [VW-1:0]         i_key,
    output logic [VW-1:0]         o_value,
    output logic                  o_hit
);
    import olis_pkg::*;

    localparam logic [CW-1:0] MY_IDX  = CW'(IDX);
    localparam logic [CW-1:0] MY_NEXT = CW'(IDX + 1);

    logic [VW-1:0] r_value, n_value;
    logic          r_hit, n_hit;

    // Pick the next entry and hit flag from the broadcast operation
    always_comb begin
        n_value = r_value;
        n_hit   = r_hit;
        case (i_cmd.op)
            OP_INSERT: begin
                if (!i_cmd.full) begin
                    if (MY_IDX == i_slot) begin
                        n_value = i_key;
                    end else if (MY_IDX > i_slot && MY_IDX <= i_len) begin
                        n_value = i_prev;
                    end
                end
            end
            OP_ROTATE: begin
                if (MY_NEXT < i_len) begin
                    n_value = i_next;
                end else if (MY_NEXT == i_len) begin
                    n_value = i_head;
                end
            end
            OP_SEARCH: begin
                n_hit = (MY_IDX < i_len) && (r_value == i_key);
            end
            default: begin
            end
        endcase
    end

    // Entry storage carries no reset
    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_hit   <= n_hit;
    end

    assign o_value = r_value;
    assign o_hit   = r_hit;

endmodule

// File: rtl/olis_chain.sv
// Row of list cells with neighbor links and a priority encoder over the
// registered hit flags. Depends on olis_pkg and olis_cell.
module olis_chain #(
    parameter int CAPACITY = 16,
    parameter int VW       = 8,
    parameter int CW       = 5,
    parameter int LW       = 5
) (
    input  logic                  i_clk,
    input  olis_pkg::t_cell_cmd   i_cmd,
    input  logic [CW-1:0]         i_slot,
    input  logic [CW-1:0]         i_len,
    input  logic [VW-1:0]         i_key,
    output logic [VW-1:0]         o_head,
    output logic                  o_found,
    output logic [LW-1:0]         o_hit_idx
);
    import olis_pkg::*;

    logic [VW-1:0]       w_val [CAPACITY];
    logic [CAPACITY-1:0] w_hit;

    // Link each cell to its neighbors; the front takes the key, the back wraps
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [VW-1:0] w_prev;
        logic [VW-1:0] w_next;

        if (g == 0) begin : g_front
            assign w_prev = i_key;
        end else begin : g_mid_prev
            assign w_prev = w_val[g-1];
        end

        if (g == CAPACITY - 1) begin : g_back
            assign w_next = w_val[0];
        end else begin : g_mid_next
            assign w_next = w_val[g+1];
        end

        olis_cell #(
            .IDX (g),
            .VW  (VW),
            .CW  (CW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (i_cmd),
            .i_slot  (i_slot),
            .i_len   (i_len),
            .i_prev  (w_prev),
            .i_next  (w_next),
            .i_head  (w_val[0]),
            .i_key   (i_key),
            .o_value (w_val[g]),
            .o_hit   (w_hit[g])
        );
    end

    assign o_head = w_val[0];

    // Find the lowest set hit flag
    always_comb begin
        o_found   = 1'b0;
        o_hit_idx = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (w_hit[i]) begin
                o_found   = 1'b1;
                o_hit_idx = LW'(i);
            end
        end
    end

endmodule

// File: rtl/ordered_list_insert_search_unit.sv
// Top level of the ordered list insert/search unit: stream ports, command
// sequencer and output register around the cell chain. Depends on olis_pkg, olis_chain.
//
//  Channel   Dir  tdata (low bit up)                       tuser         tlast
//  s_axis    in   position[4:0], value                     command[1:0]  -
//  m_axis    out  insert_status, match_position[4:0],      result_kind   last_item
//                 element_value
//
// Insert: the chain shifts every later entry back in the accepting cycle.
// Search: the cells register their compare, the encoder answers next cycle.
// Dump: after the accepting cycle the chain rotates the list through cell 0 and
// sends one beat per entry, holding while the output register is not free.
// One command is in work at a time; s_axis_tready drops while a search or dump runs
// and while the output register holds a beat that is not taken.
// Synchronous active-low reset empties the list; no clearing pass is needed.
module ordered_list_insert_search_unit #(
    parameter int CAPACITY    = 16,
    parameter int VALUE_WIDTH = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // position, value
    input  logic [((5+VALUE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    // command
    input  logic [olis_pkg::CMD_W-1:0]         s_axis_tuser,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // insert_status, match_position, element_value
    output logic [((6+VALUE_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    // result_kind
    output logic [olis_pkg::KIND_W-1:0]        m_axis_tuser,
    output logic                               m_axis_tlast,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready
);
    import olis_pkg::*;

    localparam int LW = $clog2(CAPACITY + 1);
    localparam int CW = (LW > POS_W) ? LW : POS_W;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_DUMP   = 2'd2;

    // Control state
    logic [1:0]    r_state, n_state;
    logic [LW-1:0] r_len, n_len;
    logic [LW-1:0] r_cnt, n_cnt;
    logic          r_out_valid, n_out_valid;

    // Output payload
    logic [KIND_W-1:0]      r_out_kind, n_out_kind;
    logic                   r_out_status, n_out_status;
    logic [POS_W-1:0]       r_out_match, n_out_match;
    logic [VALUE_WIDTH-1:0] r_out_elem, n_out_elem;
    logic                   r_out_last, n_out_last;

    logic [POS_W-1:0]       w_pos;
    logic [VALUE_WIDTH-1:0] w_key;
    logic [POS_W-1:0]       w_pos_m1;
    logic [CW-1:0]          w_pos_ext;
    logic [CW-1:0]          w_len_ext;
    logic [CW-1:0]          w_slot;
    logic [CW-1:0]          w_match_ext;
    logic                   w_out_free;
    logic                   w_accept;
    logic                   w_full;
    logic                   w_dump_last;
    t_cell_cmd              w_cell_cmd;
    logic [VALUE_WIDTH-1:0] w_head;
    logic                   w_found;
    logic [LW-1:0]          w_hit_idx;

    // Unpack the input beat
    assign w_pos = s_axis_tdata[POS_W-1:0];
    assign w_key = s_axis_tdata[POS_W+VALUE_WIDTH-1:POS_W];

    // Insert slot: position zero means front, past the end means append
    assign w_pos_m1  = (w_pos == '0) ? '0 : w_pos - POS_W'(1);
    assign w_pos_ext = CW'(w_pos_m1);
    assign w_len_ext = CW'(r_len);
    assign w_slot    = (w_pos_ext > w_len_ext) ? w_len_ext : w_pos_ext;

    assign w_full      = (r_len == LW'(CAPACITY));
    assign w_out_free  = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE) && w_out_free;
    assign w_accept    = s_axis_tvalid && s_axis_tready;
    assign w_dump_last = (r_cnt == r_len - LW'(1));
    assign w_match_ext = CW'(w_hit_idx) + CW'(1);

    // Sequence commands and load the output register
    always_comb begin
        n_state      = r_state;
        n_len        = r_len;
        n_cnt        = r_cnt;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_kind   = r_out_kind;
        n_out_status = r_out_status;
        n_out_match  = r_out_match;
        n_out_elem   = r_out_elem;
        n_out_last   = r_out_last;
        w_cell_cmd.op   = OP_HOLD;
        w_cell_cmd.full = w_full;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    case (s_axis_tuser)
                        CMD_INSERT: begin
                            n_out_valid  = 1'b1;
                            n_out_kind   = KIND_INSERT;
                            n_out_status = w_full;
                            n_out_match  = '0;
                            n_out_elem   = '0;
                            n_out_last   = 1'b1;
                            if (!w_full) begin
                                w_cell_cmd.op = OP_INSERT;
                                n_len         = r_len + LW'(1);
                            end
                        end
                        CMD_SEARCH: begin
                            w_cell_cmd.op = OP_SEARCH;
                            n_state       = ST_SEARCH;
                        end
                        CMD_DUMP: begin
                            if (r_len != '0) begin
                                n_state = ST_DUMP;
                                n_cnt   = '0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SEARCH: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_kind   = KIND_SEARCH;
                    n_out_status = 1'b0;
                    n_out_match  = w_found ? w_match_ext[POS_W-1:0] : '0;
                    n_out_elem   = '0;
                    n_out_last   = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            ST_DUMP: begin
                if (w_out_free) begin
                    n_out_valid   = 1'b1;
                    n_out_kind    = KIND_DUMP;
                    n_out_status  = 1'b0;
                    n_out_match   = '0;
                    n_out_elem    = w_head;
                    n_out_last    = w_dump_last;
                    w_cell_cmd.op = OP_ROTATE;
                    n_cnt         = r_cnt + LW'(1);
                    if (w_dump_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_len       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // Output payload registers
    always_ff @(posedge i_clk) begin
        r_out_kind   <= n_out_kind;
        r_out_status <= n_out_status;
        r_out_match  <= n_out_match;
        r_out_elem   <= n_out_elem;
        r_out_last   <= n_out_last;
    end

    olis_chain #(
        .CAPACITY (CAPACITY),
        .VW       (VALUE_WIDTH),
        .CW       (CW),
        .LW       (LW)
    ) u_chain (
        .i_clk     (i_clk),
        .i_cmd     (w_cell_cmd),
        .i_slot    (w_slot),
        .i_len     (w_len_ext),
        .i_key     (w_key),
        .o_head    (w_head),
        .o_found   (w_found),
        .o_hit_idx (w_hit_idx)
    );

    // Pack the output beat
    always_comb begin
        m_axis_tdata = '0;
        m_axis_tdata[0] = r_out_status;
        m_axis_tdata[POS_W:1] = r_out_match;
        m_axis_tdata[POS_W+VALUE_WIDTH:POS_W+1] = r_out_elem;
    end

    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tvalid = r_out_valid;

endmodule

// File: rtl/olis_checker.sv
// Port-level checker for the ordered list insert/search unit, bound to the top level.
// Depends on olis_pkg and the assertion macro header.
`include "ordered_list_insert_search_unit_macros.svh"

module olis_checker #(
    parameter int VALUE_WIDTH = 8
) (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic [((5+VALUE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    input logic [olis_pkg::CMD_W-1:0]         s_axis_tuser,
    input logic                               s_axis_tvalid,
    input logic                               s_axis_tready,
    input logic [((6+VALUE_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    input logic [olis_pkg::KIND_W-1:0]        m_axis_tuser,
    input logic                               m_axis_tlast,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready
);
    import olis_pkg::*;

    logic w_stall;
    logic w_not_dump;
    logic w_dump_mid;
    logic [VALUE_WIDTH-1:0] w_elem;

    assign w_stall    = m_axis_tvalid && !m_axis_tready;
    assign w_not_dump = m_axis_tvalid && (m_axis_tuser != KIND_DUMP);
    assign w_dump_mid = m_axis_tvalid && (m_axis_tuser == KIND_DUMP) && !m_axis_tlast;
    assign w_elem     = m_axis_tdata[VALUE_WIDTH+5:6];

    // Hold a stalled output beat
    `OLIS_ASSERT_NEXT(a_out_hold, w_stall, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    // Insert and search answers are single beats
    `OLIS_ASSERT_IMPL(a_single_last, w_not_dump, m_axis_tlast)
    // Only dump beats carry an element value
    `OLIS_ASSERT_IMPL(a_elem_zero, w_not_dump, w_elem == '0)
    // Take no new command while a dump is still streaming
    `OLIS_ASSERT_IMPL(a_dump_block, w_dump_mid, !s_axis_tready)

endmodule

bind ordered_list_insert_search_unit olis_checker #(
    .VALUE_WIDTH (VALUE_WIDTH)
) u_olis_checker (.*);
